// File: hw/rtl/cmac_pkg.sv
package cmac_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_ORDER_LIMIT_DEF = 8;
	localparam int RADIAL_DEPTH_DEF    = 64;

	// Field widths fixed by the interface.
	localparam int ORD_W      = 4;
	localparam int DIR_W      = 16;
	localparam int WGT_W      = 24;
	localparam int SUM_W      = 48;
	localparam int BIN_W      = 6;
	localparam int BINS_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ORDER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_BINS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_EVEN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_EVEN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Z_EVEN      = 3'd4;

	typedef enum logic [1:0] {
		OP_ACCUM = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_DECODE,
		ST_POWERS,
		ST_TERMS,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_DRAIN3,
		ST_RD_ADDR,
		ST_RD_TAKE,
		ST_CLR_BIN,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic setup;
		logic pow_step;
		logic term_run;
		logic rd_issue;
		logic rd_take;
		logic bin_clear;
		logic init_clear;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic bin_ok;
		logic rd_ok;
		logic pow_done;
		logic term_last;
		logic init_last;
	} stat_t;

	// Q1.14 product with round half up and 16-bit saturation.
	function automatic logic signed [15:0] q14_mul(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [31:0] p;
		logic signed [32:0] t;
		logic signed [18:0] r;
		p = a * b;
		t = 33'(p) + 33'sd8192;
		r = 19'(t >>> 14);
		if (r > 19'sd32767) begin
			return 16'sd32767;
		end else if (r < -19'sd32768) begin
			return -16'sd32768;
		end
		return 16'(r);
	endfunction

	// Weight times monomial, rounded back to Q32.16.
	function automatic logic signed [SUM_W-1:0] weight_inc(
		input logic signed [WGT_W-1:0] w, input logic signed [15:0] m);
		logic signed [39:0] p;
		logic signed [40:0] t;
		p = w * m;
		t = 41'(p) + 41'sd8192;
		return SUM_W'(t >>> 14);
	endfunction

	// Saturating 48-bit accumulate.
	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
		input logic signed [SUM_W-1:0] inc);
		logic signed [SUM_W:0] r;
		logic signed [SUM_W:0] hi;
		logic signed [SUM_W:0] lo;
		hi = (SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}});
		lo = -hi - 1;
		r = (SUM_W+1)'(s) + (SUM_W+1)'(inc);
		if (r > hi) begin
			return {1'b0, {(SUM_W-1){1'b1}}};
		end else if (r < lo) begin
			return {1'b1, {(SUM_W-1){1'b0}}};
		end
		return SUM_W'(r);
	endfunction

	// Count of order triples with total order up to m.
	function automatic int tet(input int m);
		int r;
		case (m)
			0:       r = 1;
			1:       r = 4;
			2:       r = 10;
			3:       r = 20;
			4:       r = 35;
			5:       r = 56;
			6:       r = 84;
			7:       r = 120;
			8:       r = 165;
			9:       r = 220;
			10:      r = 286;
			11:      r = 364;
			12:      r = 455;
			default: r = 0;
		endcase
		return r;
	endfunction

	// Count of order pairs with total order up to m.
	function automatic int tri_cnt(input int m);
		return ((m + 1) * (m + 2)) >>> 1;
	endfunction

	// Position of a triple in x-major, then y, then z order of the table.
	function automatic int term_index(input logic [ORD_W-1:0] a, input logic [ORD_W-1:0] b,
		input logic [ORD_W-1:0] c, input int lim);
		int la;
		la = lim - int'(a);
		return tet(lim) - tet(la) + tri_cnt(la) - tri_cnt(la - int'(b)) + int'(c);
	endfunction

endpackage

// File: hw/rtl/cmac_ram.sv
module cmac_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/cmac_ctrl.sv
module cmac_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cmac_pkg::stat_t stat,
	output cmac_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done
);

	cmac_pkg::state_t state_q;
	cmac_pkg::state_t state_d;

	// State register; reset starts the clearing pass over the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmac_pkg::ST_INIT_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cmac_pkg::ST_INIT_CLR: begin
				if (stat.init_last) state_d = cmac_pkg::ST_IDLE;
			end
			cmac_pkg::ST_IDLE: begin
				if (start) state_d = cmac_pkg::ST_DECODE;
			end
			cmac_pkg::ST_DECODE: begin
				if (stat.op == cmac_pkg::OP_NONE || !stat.bin_ok) begin
					state_d = cmac_pkg::ST_RESULT;
				end else begin
					unique case (stat.op)
						cmac_pkg::OP_ACCUM: state_d = cmac_pkg::ST_POWERS;
						cmac_pkg::OP_READ:
							state_d = stat.rd_ok ? cmac_pkg::ST_RD_ADDR : cmac_pkg::ST_RESULT;
						cmac_pkg::OP_CLEAR: state_d = cmac_pkg::ST_CLR_BIN;
						default:            state_d = cmac_pkg::ST_RESULT;
					endcase
				end
			end
			cmac_pkg::ST_POWERS: begin
				if (stat.pow_done) state_d = cmac_pkg::ST_TERMS;
			end
			cmac_pkg::ST_TERMS: begin
				if (stat.term_last) state_d = cmac_pkg::ST_DRAIN1;
			end
			cmac_pkg::ST_DRAIN1:  state_d = cmac_pkg::ST_DRAIN2;
			cmac_pkg::ST_DRAIN2:  state_d = cmac_pkg::ST_DRAIN3;
			cmac_pkg::ST_DRAIN3:  state_d = cmac_pkg::ST_RESULT;
			cmac_pkg::ST_RD_ADDR: state_d = cmac_pkg::ST_RD_TAKE;
			cmac_pkg::ST_RD_TAKE: state_d = cmac_pkg::ST_RESULT;
			cmac_pkg::ST_CLR_BIN: begin
				if (stat.term_last) state_d = cmac_pkg::ST_RESULT;
			end
			cmac_pkg::ST_RESULT:  state_d = cmac_pkg::ST_IDLE;
			default:              state_d = cmac_pkg::ST_IDLE;
		endcase
	end

	// Outputs decoded from the current state.
	always_comb begin
		cmd            = '0;
		cmd.latch      = (state_q == cmac_pkg::ST_IDLE) && start;
		cmd.setup      = (state_q == cmac_pkg::ST_DECODE);
		cmd.pow_step   = (state_q == cmac_pkg::ST_POWERS) && !stat.pow_done;
		cmd.term_run   = (state_q == cmac_pkg::ST_TERMS);
		cmd.rd_issue   = (state_q == cmac_pkg::ST_RD_ADDR);
		cmd.rd_take    = (state_q == cmac_pkg::ST_RD_TAKE);
		cmd.bin_clear  = (state_q == cmac_pkg::ST_CLR_BIN);
		cmd.init_clear = (state_q == cmac_pkg::ST_INIT_CLR);
		busy           = (state_q != cmac_pkg::ST_IDLE);
		done           = (state_q == cmac_pkg::ST_RESULT);
	end

	// A result strobe always follows a busy cycle and lasts one cycle.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");
	a_latch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> (state_q == cmac_pkg::ST_DECODE))
		else $error("accepted transaction not decoded");

endmodule

// File: hw/rtl/cmac_datapath.sv
module cmac_datapath #(
	parameter int MAX_ORDER_LIMIT = cmac_pkg::MAX_ORDER_LIMIT_DEF,
	parameter int RADIAL_DEPTH    = cmac_pkg::RADIAL_DEPTH_DEF,
	parameter int RAM_AW          = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [cmac_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cmac_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [1:0]                           operation,
	input  logic signed [cmac_pkg::DIR_W-1:0]    dir_x,
	input  logic signed [cmac_pkg::DIR_W-1:0]    dir_y,
	input  logic signed [cmac_pkg::DIR_W-1:0]    dir_z,
	input  logic signed [cmac_pkg::WGT_W-1:0]    sample_weight,
	input  logic [cmac_pkg::BIN_W-1:0]           radial_bin,
	input  logic [cmac_pkg::ORD_W-1:0]           order_x,
	input  logic [cmac_pkg::ORD_W-1:0]           order_y,
	input  logic [cmac_pkg::ORD_W-1:0]           order_z,
	input  cmac_pkg::cmd_t                       cmd,
	output cmac_pkg::stat_t                      stat,
	output logic                                 ram_we,
	output logic [RAM_AW-1:0]                    ram_waddr,
	output logic [cmac_pkg::SUM_W-1:0]           ram_wdata,
	output logic [RAM_AW-1:0]                    ram_raddr,
	input  logic [cmac_pkg::SUM_W-1:0]           ram_rdata,
	output logic signed [cmac_pkg::SUM_W-1:0]    element_value,
	output logic                                 status
);

	localparam int TERMS = (MAX_ORDER_LIMIT + 1) * (MAX_ORDER_LIMIT + 2)
		* (MAX_ORDER_LIMIT + 3) / 6;
	localparam int TW    = $clog2(TERMS + 1);
	localparam int OW    = (MAX_ORDER_LIMIT > 0) ? $clog2(MAX_ORDER_LIMIT + 1) : 1;
	localparam int PN    = 1 << OW;
	localparam int DEPTH = RADIAL_DEPTH << TW;
	localparam int BLW   = $clog2(RADIAL_DEPTH + 1);
	localparam int CW    = (BLW > cmac_pkg::BINS_W) ? BLW : cmac_pkg::BINS_W;

	// Configuration registers.
	logic [cmac_pkg::ORD_W-1:0]  max_order_q;
	logic [cmac_pkg::BINS_W-1:0] radial_bins_q;
	logic                        x_even_q;
	logic                        y_even_q;
	logic                        z_even_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_order_q   <= 4'd4;
			radial_bins_q <= 7'd25;
			x_even_q      <= 1'b0;
			y_even_q      <= 1'b0;
			z_even_q      <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cmac_pkg::REG_MAX_ORDER:   max_order_q   <= cfg_wdata[cmac_pkg::ORD_W-1:0];
				cmac_pkg::REG_RADIAL_BINS: radial_bins_q <= cfg_wdata;
				cmac_pkg::REG_X_EVEN:      x_even_q      <= cfg_wdata[0];
				cmac_pkg::REG_Y_EVEN:      y_even_q      <= cfg_wdata[0];
				cmac_pkg::REG_Z_EVEN:      z_even_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Captured transaction.
	cmac_pkg::op_t                     op_q;
	logic signed [cmac_pkg::DIR_W-1:0] dx_q;
	logic signed [cmac_pkg::DIR_W-1:0] dy_q;
	logic signed [cmac_pkg::DIR_W-1:0] dz_q;
	logic signed [cmac_pkg::WGT_W-1:0] w_q;
	logic [cmac_pkg::BIN_W-1:0]        bin_q;
	logic [cmac_pkg::ORD_W-1:0]        ox_q;
	logic [cmac_pkg::ORD_W-1:0]        oy_q;
	logic [cmac_pkg::ORD_W-1:0]        oz_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= cmac_pkg::op_t'(operation);
			dx_q  <= dir_x;
			dy_q  <= dir_y;
			dz_q  <= dir_z;
			w_q   <= sample_weight;
			bin_q <= radial_bin;
			ox_q  <= order_x;
			oy_q  <= order_y;
			oz_q  <= order_z;
		end
	end

	// Effective limits and checks of the captured transaction.
	logic [cmac_pkg::ORD_W-1:0] emax;
	logic [CW-1:0]              bin_lim;
	logic [5:0]                 osum;
	logic                       bin_ok;
	logic                       rd_ok;

	always_comb begin
		emax    = (max_order_q > cmac_pkg::ORD_W'(MAX_ORDER_LIMIT))
			? cmac_pkg::ORD_W'(MAX_ORDER_LIMIT) : max_order_q;
		bin_lim = (CW'(radial_bins_q) > CW'(RADIAL_DEPTH)) ? CW'(RADIAL_DEPTH)
			: CW'(radial_bins_q);
		bin_ok  = CW'(bin_q) < bin_lim;
		osum    = 6'(ox_q) + 6'(oy_q) + 6'(oz_q);
		rd_ok   = (osum <= 6'(emax)) && !(x_even_q && ox_q[0])
			&& !(y_even_q && oy_q[0]) && !(z_even_q && oz_q[0]);
	end

	// Power tables, one new power per axis each step.
	logic signed [15:0] px_q [0:PN-1];
	logic signed [15:0] py_q [0:PN-1];
	logic signed [15:0] pz_q [0:PN-1];
	logic signed [15:0] curx_q;
	logic signed [15:0] cury_q;
	logic signed [15:0] curz_q;
	logic [OW-1:0]      pk_q;
	logic signed [15:0] nx;
	logic signed [15:0] ny;
	logic signed [15:0] nz;

	always_comb begin
		nx = cmac_pkg::q14_mul(curx_q, dx_q);
		ny = cmac_pkg::q14_mul(cury_q, dy_q);
		nz = cmac_pkg::q14_mul(curz_q, dz_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			curx_q   <= 16'sd16384;
			cury_q   <= 16'sd16384;
			curz_q   <= 16'sd16384;
			px_q[0]  <= 16'sd16384;
			py_q[0]  <= 16'sd16384;
			pz_q[0]  <= 16'sd16384;
		end else if (cmd.pow_step) begin
			curx_q <= nx;
			cury_q <= ny;
			curz_q <= nz;
			px_q[OW'(pk_q + 1'b1)] <= nx;
			py_q[OW'(pk_q + 1'b1)] <= ny;
			pz_q[OW'(pk_q + 1'b1)] <= nz;
		end
	end

	// Term walk counters, in the table's x-major order.
	logic [OW-1:0] a_q;
	logic [OW-1:0] b_q;
	logic [OW-1:0] c_q;
	logic [TW-1:0] n_q;
	logic [5:0]    sabc;
	logic [5:0]    sab;
	logic          term_valid;

	always_comb begin
		sab        = 6'(a_q) + 6'(b_q);
		sabc       = sab + 6'(c_q);
		term_valid = (sabc <= 6'(emax)) && !(x_even_q && a_q[0])
			&& !(y_even_q && b_q[0]) && !(z_even_q && c_q[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_q <= '0;
			a_q  <= '0;
			b_q  <= '0;
			c_q  <= '0;
			n_q  <= '0;
		end else if (cmd.setup) begin
			pk_q <= '0;
			a_q  <= '0;
			b_q  <= '0;
			c_q  <= '0;
			n_q  <= '0;
		end else begin
			if (cmd.pow_step) begin
				pk_q <= pk_q + 1'b1;
			end
			if (cmd.term_run || cmd.bin_clear) begin
				n_q <= n_q + 1'b1;
				if (sabc < 6'(MAX_ORDER_LIMIT)) begin
					c_q <= c_q + 1'b1;
				end else begin
					c_q <= '0;
					if (sab < 6'(MAX_ORDER_LIMIT)) begin
						b_q <= b_q + 1'b1;
					end else begin
						b_q <= '0;
						a_q <= a_q + 1'b1;
					end
				end
			end
		end
	end

	// Update pipeline: two monomial products, weight product, then add.
	logic                           we_s1;
	logic                           we_s2;
	logic                           we_s3;
	logic signed [15:0]             m1_s1;
	logic signed [15:0]             pz_s1;
	logic signed [15:0]             m2_s2;
	logic signed [cmac_pkg::SUM_W-1:0] inc_s3;
	logic [RAM_AW-1:0]              addr_s1;
	logic [RAM_AW-1:0]              addr_s2;
	logic [RAM_AW-1:0]              addr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
			we_s2 <= 1'b0;
			we_s3 <= 1'b0;
		end else begin
			we_s1 <= cmd.term_run && term_valid;
			we_s2 <= we_s1;
			we_s3 <= we_s2;
		end
	end

	always_ff @(posedge clk) begin
		m1_s1   <= cmac_pkg::q14_mul(px_q[a_q], py_q[b_q]);
		pz_s1   <= pz_q[c_q];
		addr_s1 <= RAM_AW'({bin_q, n_q});
		m2_s2   <= cmac_pkg::q14_mul(m1_s1, pz_s1);
		addr_s2 <= addr_s1;
		inc_s3  <= cmac_pkg::weight_inc(w_q, m2_s2);
		addr_s3 <= addr_s2;
	end

	// Reset clearing pass counter.
	logic [RAM_AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.init_clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Store port selection.
	logic [RAM_AW-1:0] rd_addr;

	always_comb begin
		rd_addr   = RAM_AW'({bin_q, TW'(cmac_pkg::term_index(ox_q, oy_q, oz_q,
			MAX_ORDER_LIMIT))});
		ram_raddr = cmd.rd_issue ? rd_addr : addr_s2;
		if (cmd.init_clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (cmd.bin_clear) begin
			ram_we    = 1'b1;
			ram_waddr = RAM_AW'({bin_q, n_q});
			ram_wdata = '0;
		end else begin
			ram_we    = we_s3;
			ram_waddr = addr_s3;
			ram_wdata = cmac_pkg::sat_add(ram_rdata, inc_s3);
		end
	end

	// Result registers.
	logic signed [cmac_pkg::SUM_W-1:0] value_q;
	logic                              status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q  <= '0;
			status_q <= 1'b0;
		end else if (cmd.setup) begin
			value_q  <= '0;
			status_q <= (op_q != cmac_pkg::OP_NONE)
				&& (!bin_ok || (op_q == cmac_pkg::OP_READ && !rd_ok));
		end else if (cmd.rd_take) begin
			value_q <= ram_rdata;
		end
	end

	assign element_value = value_q;
	assign status        = status_q;

	always_comb begin
		stat           = '0;
		stat.op        = op_q;
		stat.bin_ok    = bin_ok;
		stat.rd_ok     = rd_ok;
		stat.pow_done  = (pk_q == OW'(MAX_ORDER_LIMIT));
		stat.term_last = (n_q == TW'(TERMS - 1));
		stat.init_last = (clr_q == RAM_AW'(DEPTH - 1));
	end

	// Pipeline writes never collide with a clearing sweep.
	a_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		we_s3 |-> !(cmd.init_clear || cmd.bin_clear))
		else $error("update write collides with clear");
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.term_run |-> (n_q <= TW'(TERMS - 1)))
		else $error("term counter beyond table");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		status_q |-> (value_q == '0))
		else $error("error result carries a value");

endmodule

// File: hw/rtl/cartesian_moment_accumulator_unit.sv
// Moment accumulator. A transaction is accepted when start is high and busy is
// low; its single result is on element_value and status while done is high for
// one cycle, and the receiver cannot stall it. An accumulate first runs a power
// phase, then walks every order triple of the table through the update pipeline,
// taking a new triple before the last one has been written; a store
// read-modify-write is done only for the triples that the configured limits allow.
// After reset the store is cleared one entry per cycle, over all
// RADIAL_DEPTH * 2^ceil(log2(TERMS+1)) entries (16384 with defaults), with busy
// high; configuration writes are taken at any time.
module cartesian_moment_accumulator_unit #(
	parameter int MAX_ORDER_LIMIT = cmac_pkg::MAX_ORDER_LIMIT_DEF,
	parameter int RADIAL_DEPTH    = cmac_pkg::RADIAL_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [cmac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cmac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic signed [cmac_pkg::DIR_W-1:0] dir_x,
	input  logic signed [cmac_pkg::DIR_W-1:0] dir_y,
	input  logic signed [cmac_pkg::DIR_W-1:0] dir_z,
	input  logic signed [cmac_pkg::WGT_W-1:0] sample_weight,
	input  logic [cmac_pkg::BIN_W-1:0]        radial_bin,
	input  logic [cmac_pkg::ORD_W-1:0]        order_x,
	input  logic [cmac_pkg::ORD_W-1:0]        order_y,
	input  logic [cmac_pkg::ORD_W-1:0]        order_z,
	output logic                              done,
	output logic signed [cmac_pkg::SUM_W-1:0] element_value,
	output logic                              status
);

	localparam int TERMS  = (MAX_ORDER_LIMIT + 1) * (MAX_ORDER_LIMIT + 2)
		* (MAX_ORDER_LIMIT + 3) / 6;
	localparam int TW     = $clog2(TERMS + 1);
	localparam int DEPTH  = RADIAL_DEPTH << TW;
	localparam int RAM_AW = $clog2(DEPTH);

	cmac_pkg::cmd_t             cmd;
	cmac_pkg::stat_t            stat;
	logic                       ram_we;
	logic [RAM_AW-1:0]          ram_waddr;
	logic [cmac_pkg::SUM_W-1:0] ram_wdata;
	logic [RAM_AW-1:0]          ram_raddr;
	logic [cmac_pkg::SUM_W-1:0] ram_rdata;

	cmac_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cmac_datapath #(
		.MAX_ORDER_LIMIT (MAX_ORDER_LIMIT),
		.RADIAL_DEPTH    (RADIAL_DEPTH),
		.RAM_AW          (RAM_AW)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.operation     (operation),
		.dir_x         (dir_x),
		.dir_y         (dir_y),
		.dir_z         (dir_z),
		.sample_weight (sample_weight),
		.radial_bin    (radial_bin),
		.order_x       (order_x),
		.order_y       (order_y),
		.order_z       (order_z),
		.cmd           (cmd),
		.stat          (stat),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.element_value (element_value),
		.status        (status)
	);

	cmac_ram #(
		.WIDTH (cmac_pkg::SUM_W),
		.DEPTH (DEPTH)
	) u_sums (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
